/* hw/rtl/rfsc_pkg.sv */
// Package with the shared constants, codes and types of the ring FIFO with snapshot cursor.
`default_nettype none
package rfsc_pkg;

	// Storage geometry.
	localparam int SLOT_DEPTH  = 256;
	localparam int ENTRY_WIDTH = 32;
	localparam int IDX_W       = $clog2(SLOT_DEPTH);
	localparam int SLOT_W      = $clog2(SLOT_DEPTH + 1);

	// Field widths fixed by the interface.
	localparam int CMD_W    = 3;
	localparam int STATUS_W = 2;
	localparam int CAP_W    = 8;
	localparam int COUNT_W  = 8;

	localparam logic [CAP_W-1:0] CAP_RESET = 8'd255;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_PUT   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_GET   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SNAP  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SREAD = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// Per-command result fields that travel beside the memory read.
	typedef struct packed {
		logic                is_rd;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
		logic                full;
		logic                empty;
		logic                snap_done;
	} meta_t;

	// One finished result beat.
	typedef struct packed {
		logic [ENTRY_WIDTH-1:0] data;
		logic [STATUS_W-1:0]    status;
		logic [COUNT_W-1:0]     count;
		logic                   full;
		logic                   empty;
		logic                   snap_done;
	} result_t;

endpackage
`default_nettype wire

/* hw/rtl/ring_fifo_with_snapshot_cursor.sv */
// Top level of the ring FIFO with snapshot cursor: pointer logic, entry memory and output register.
`default_nettype none
// The block is a circular FIFO of queue_capacity+1 slots (one always left empty, at most
// 256 slots) whose entries live in a single synchronous memory, plus a second cursor set
// that a snapshot command loads from the live pointers. Each input beat carries one
// command: put, get, snapshot, snapshot read or clear; unknown codes change nothing and
// report ok. Every command gives exactly one result beat with the data read (zero unless
// a get or snapshot read succeeded), a status code, the live entry count and the full,
// empty and snapshot-done flags as they stand after the command. A command is accepted
// every cycle while results keep draining; its result passes through the registered
// memory read and then the output register. Pointer updates resolve in the accept cycle,
// so a get that directly follows a put of the same entry reads the new data without any
// interlock. Writing queue_capacity takes effect at once and clears all pointers and
// counts but keeps the stored entries; a capacity of zero acts as one. Entries that were
// never written read back as arbitrary data. Write the capacity only while no command is
// in flight.
module ring_fifo_with_snapshot_cursor (
	input  wire                                    clk,
	input  wire                                    arst_n,
	// Command channel.
	input  wire                                    in_valid,
	output logic                                   in_ready,
	input  wire  [rfsc_pkg::CMD_W-1:0]             command,
	input  wire  [rfsc_pkg::ENTRY_WIDTH-1:0]       data_in,
	// Result channel.
	output logic                                   out_valid,
	input  wire                                    out_ready,
	output logic [rfsc_pkg::ENTRY_WIDTH-1:0]       data_out,
	output logic [rfsc_pkg::STATUS_W-1:0]          status,
	output logic [rfsc_pkg::COUNT_W-1:0]           entry_count,
	output logic                                   is_full,
	output logic                                   is_empty,
	output logic                                   snapshot_done,
	// Capacity write channel.
	input  wire                                    cfg_valid,
	output logic                                   cfg_ready,
	input  wire  [rfsc_pkg::CAP_W-1:0]             queue_capacity
);

	localparam int IDX_W  = rfsc_pkg::IDX_W;
	localparam int SLOT_W = rfsc_pkg::SLOT_W;

	// Advance a ring index, wrapping to zero at the slot count in use.
	function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
			input logic [SLOT_W-1:0] slots);
		logic [SLOT_W-1:0] nxt;
		nxt = SLOT_W'(idx) + SLOT_W'(1);
		if (nxt >= slots) begin
			return '0;
		end
		return nxt[IDX_W-1:0];
	endfunction

	// Configuration and live pointer state.
	logic [rfsc_pkg::CAP_W-1:0]   cap_q;
	logic [IDX_W-1:0]             rear_q, front_q, snap_rear_q, snap_front_q;
	logic [rfsc_pkg::COUNT_W-1:0] count_q, snap_count_q;

	logic [IDX_W-1:0]             rear_d, front_d, snap_rear_d, snap_front_d;
	logic [rfsc_pkg::COUNT_W-1:0] count_d, snap_count_d;

	// Memory access for the accepted command.
	logic                               wr_en, rd_en;
	logic [IDX_W-1:0]                   wr_addr, rd_addr;
	logic [rfsc_pkg::ENTRY_WIDTH-1:0]   mem [rfsc_pkg::SLOT_DEPTH];
	logic [rfsc_pkg::ENTRY_WIDTH-1:0]   rd_data_s1;

	// Pipeline control.
	rfsc_pkg::meta_t   meta_d, meta_s1;
	rfsc_pkg::result_t out_q;
	logic              s1_valid_q, out_valid_q;
	logic              s1_adv, in_fire, cfg_fire;

	logic [rfsc_pkg::CAP_W-1:0] cap_eff;
	logic [SLOT_W-1:0]          slot_raw, slot_n;

	// Capacity writes are taken at any time; the user keeps them to idle periods.
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid & cfg_ready;

	// The output register frees when empty or when its beat is taken, and stage one
	// moves into it then; a new command enters whenever stage one is empty or can move on.
	assign s1_adv   = !out_valid_q || out_ready;
	assign in_ready = !s1_valid_q || s1_adv;
	assign in_fire  = in_valid & in_ready;

	// Slot count: capacity plus one, a zero capacity acting as one, capped at the store.
	always_comb begin
		cap_eff  = (cap_q == '0) ? rfsc_pkg::CAP_W'(1) : cap_q;
		slot_raw = SLOT_W'(cap_eff) + SLOT_W'(1);
		slot_n   = (slot_raw > SLOT_W'(rfsc_pkg::SLOT_DEPTH)) ?
			SLOT_W'(rfsc_pkg::SLOT_DEPTH) : slot_raw;
	end

	// Decode the command against the current pointers. All flags reported in the
	// result are taken from the updated pointers.
	always_comb begin
		rear_d       = rear_q;
		front_d      = front_q;
		count_d      = count_q;
		snap_rear_d  = snap_rear_q;
		snap_front_d = snap_front_q;
		snap_count_d = snap_count_q;
		wr_en        = 1'b0;
		rd_en        = 1'b0;
		wr_addr      = rear_q;
		rd_addr      = front_q;
		meta_d       = '0;
		meta_d.status = rfsc_pkg::ST_OK;
		case (command)
			rfsc_pkg::CMD_PUT: begin
				if (front_q == advance(rear_q, slot_n)) begin
					meta_d.status = rfsc_pkg::ST_FULL;
				end else begin
					wr_en   = in_fire;
					rear_d  = advance(rear_q, slot_n);
					count_d = count_q + rfsc_pkg::COUNT_W'(1);
				end
			end
			rfsc_pkg::CMD_GET: begin
				if (front_q == rear_q) begin
					meta_d.status = rfsc_pkg::ST_EMPTY;
				end else begin
					rd_en        = in_fire;
					meta_d.is_rd = 1'b1;
					front_d      = advance(front_q, slot_n);
					count_d      = count_q - rfsc_pkg::COUNT_W'(1);
				end
			end
			rfsc_pkg::CMD_SNAP: begin
				snap_rear_d  = rear_q;
				snap_front_d = front_q;
				snap_count_d = count_q;
			end
			rfsc_pkg::CMD_SREAD: begin
				rd_addr = snap_front_q;
				if (snap_front_q == snap_rear_q) begin
					meta_d.status = rfsc_pkg::ST_EMPTY;
				end else begin
					rd_en        = in_fire;
					meta_d.is_rd = 1'b1;
					snap_front_d = advance(snap_front_q, slot_n);
					snap_count_d = snap_count_q - rfsc_pkg::COUNT_W'(1);
				end
			end
			rfsc_pkg::CMD_CLEAR: begin
				rear_d       = '0;
				front_d      = '0;
				count_d      = '0;
				snap_rear_d  = '0;
				snap_front_d = '0;
				snap_count_d = '0;
			end
			default: begin
			end
		endcase
		meta_d.count     = count_d;
		meta_d.full      = (front_d == advance(rear_d, slot_n));
		meta_d.empty     = (front_d == rear_d);
		meta_d.snap_done = (snap_front_d == snap_rear_d);
	end

	// Pointer and capacity registers. A capacity write clears every pointer and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q        <= rfsc_pkg::CAP_RESET;
			rear_q       <= '0;
			front_q      <= '0;
			count_q      <= '0;
			snap_rear_q  <= '0;
			snap_front_q <= '0;
			snap_count_q <= '0;
		end else if (cfg_fire) begin
			cap_q        <= queue_capacity;
			rear_q       <= '0;
			front_q      <= '0;
			count_q      <= '0;
			snap_rear_q  <= '0;
			snap_front_q <= '0;
			snap_count_q <= '0;
		end else if (in_fire) begin
			rear_q       <= rear_d;
			front_q      <= front_d;
			count_q      <= count_d;
			snap_rear_q  <= snap_rear_d;
			snap_front_q <= snap_front_d;
			snap_count_q <= snap_count_d;
		end
	end

	// Entry memory: one write and one registered read per cycle. The read register
	// holds while stage one is stalled, since no new read is issued then.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= data_in;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// Stage one carries the result fields beside the memory read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_fire) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			meta_s1 <= meta_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_valid_q && s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && s1_adv) begin
			out_q.data      <= meta_s1.is_rd ? rd_data_s1 : '0;
			out_q.status    <= meta_s1.status;
			out_q.count     <= meta_s1.count;
			out_q.full      <= meta_s1.full;
			out_q.empty     <= meta_s1.empty;
			out_q.snap_done <= meta_s1.snap_done;
		end
	end

	assign out_valid     = out_valid_q;
	assign data_out      = out_q.data;
	assign status        = out_q.status;
	assign entry_count   = out_q.count;
	assign is_full       = out_q.full;
	assign is_empty      = out_q.empty;
	assign snapshot_done = out_q.snap_done;

`ifndef SYNTHESIS
	// Both live pointers stay inside the ring in use.
	assert property (@(posedge clk) disable iff (!arst_n)
		(SLOT_W'(rear_q) < slot_n) && (SLOT_W'(front_q) < slot_n))
		else $error("live pointer outside the ring");

	// A ring has at least two slots, so full and empty never coincide.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.full && out_q.empty))
		else $error("result reports full and empty together");

	// A stalled stage one issues no new read and keeps its beat until the output
	// register frees.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |-> (!rd_en ##1 (s1_valid_q && $stable(meta_s1))))
		else $error("stage one lost its beat while stalled");

	// A failed read returns zero data.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.status != rfsc_pkg::ST_OK)) |-> (out_q.data == '0))
		else $error("failed command returned data");

	// A command that reads the memory issues the read in its accept cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && meta_d.is_rd) |-> rd_en)
		else $error("read command without memory read");
`endif

endmodule
`default_nettype wire
